>>> rtl/core/jdf_pkg.sv
// jdf_pkg: shared constants, beat types and queue control types for the job dispatcher
// no dependencies

package jdf_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int WORKERS     = 3;

   localparam int JOB_W   = 16;
   localparam int WIDX_W  = 3;
   localparam int TIME_W  = 32;
   localparam int QA_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int WK_W    = $clog2(WORKERS + 1);
   localparam int WSEL_W  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int EV_W    = $clog2(2 * WORKERS + 1);
   localparam int ENTRY_W = 2 * JOB_W;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic EV_FINISHED = 1'b0;
   localparam logic EV_STARTED  = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [JOB_W-1:0] job_id;
      logic [JOB_W-1:0] job_length;
   } req_type;

   typedef struct packed {
      logic              event_kind;
      logic [WIDX_W-1:0] worker_index;
      logic [JOB_W-1:0]  event_job_id;
      logic [JOB_W-1:0]  event_length;
      logic [TIME_W-1:0] tick_count;
      logic              last_event;
   } rsp_type;

   typedef struct packed {
      logic [JOB_W-1:0] id;
      logic [JOB_W-1:0] len;
   } entry_type;

   typedef struct packed {
      logic push;
      logic rd;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
   } q_stat_type;

endpackage

>>> rtl/core/jdf_ram.sv
// jdf_ram: generic single write port, single read port ram with registered read
// no dependencies

module jdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/jdf_queue.sv
// jdf_queue: ring queue of pending jobs, pointers and fill count around one ram
// depends on jdf_pkg and jdf_ram

module jdf_queue (
   input  logic               clock,
   input  logic               reset,
   input  jdf_pkg::q_ctrl_type ctrl,
   input  jdf_pkg::entry_type wdata,
   output jdf_pkg::entry_type rdata,
   output jdf_pkg::q_stat_type stat
);

   logic [jdf_pkg::QA_W-1:0]    head_ff, head_in;
   logic [jdf_pkg::QA_W-1:0]    tail_ff, tail_in;
   logic [jdf_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                        do_push;
   logic [jdf_pkg::ENTRY_W-1:0] wbits;
   logic [jdf_pkg::ENTRY_W-1:0] rbits;

   assign do_push = ctrl.push && (count_ff < jdf_pkg::CNT_W'(jdf_pkg::QUEUE_DEPTH));
   assign wbits   = wdata;
   assign rdata   = jdf_pkg::entry_type'(rbits);
   assign stat.count = count_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in  = (tail_ff == jdf_pkg::QA_W'(jdf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (ctrl.pop) begin
         head_in  = (head_ff == jdf_pkg::QA_W'(jdf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   jdf_ram #(
      .WIDTH(jdf_pkg::ENTRY_W),
      .DEPTH(jdf_pkg::QUEUE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (do_push),
      .waddr (tail_ff),
      .wdata (wbits),
      .re    (ctrl.rd),
      .raddr (head_ff),
      .rdata (rbits)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= jdf_pkg::CNT_W'(jdf_pkg::QUEUE_DEPTH))
      else $error("queue fill count above depth");

   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.push && ctrl.pop))
      else $error("queue push and pop in one cycle");

endmodule

>>> rtl/core/job_dispatcher_fifo_agents.sv
// job_dispatcher_fifo_agents: top level, tick sequencer, worker registers, result register
// depends on jdf_pkg and jdf_queue
//
// channel  dir  handshake              beat
// req      in   req_valid/req_ready    jdf_pkg::req_type
// rsp      out  rsp_valid/rsp_ready    jdf_pkg::rsp_type
//
// an add beat writes the queue ram directly
// a tick beat runs the finish scan over every worker, then checks each worker for a start
// until the queue is empty, with one queue ram read state per start, and then closes
// back to idle
// reset is synchronous and leaves the queue empty, no clearing pass
// a full result register stalls the sequencer; req_ready is low while a tick is in work

module job_dispatcher_fifo_agents (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jdf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jdf_pkg::rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FIN  = 2'd1;
   localparam logic [1:0] ST_STR  = 2'd2;
   localparam logic [1:0] ST_STW  = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [jdf_pkg::WK_W-1:0]    w_ff, w_in;
   logic [jdf_pkg::WORKERS-1:0] busy_ff, busy_in;
   logic [jdf_pkg::JOB_W-1:0]   job_ff [jdf_pkg::WORKERS];
   logic [jdf_pkg::JOB_W-1:0]   job_in [jdf_pkg::WORKERS];
   logic [jdf_pkg::JOB_W-1:0]   rem_ff [jdf_pkg::WORKERS];
   logic [jdf_pkg::JOB_W-1:0]   rem_in [jdf_pkg::WORKERS];
   logic [jdf_pkg::TIME_W-1:0]  time_ff, time_in;
   logic [jdf_pkg::EV_W-1:0]    ev_cnt_ff, ev_cnt_in;
   logic [jdf_pkg::EV_W-1:0]    ev_total_ff, ev_total_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   jdf_pkg::rsp_type            rsp_ff, rsp_in;
   jdf_pkg::q_ctrl_type         q_ctrl;
   jdf_pkg::q_stat_type         q_stat;
   jdf_pkg::entry_type          q_wdata;
   jdf_pkg::entry_type          q_rdata;
   logic [jdf_pkg::EV_W-1:0]    tick_total;
   logic                        emit_ok;
   logic [jdf_pkg::WSEL_W-1:0]  widx;
   logic                        is_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   assign widx      = w_ff[jdf_pkg::WSEL_W-1:0];
   assign is_last   = (ev_cnt_ff == ev_total_ff - 1'b1);
   assign q_wdata.id  = req_data.job_id;
   assign q_wdata.len = req_data.job_length;

   // number of events the next tick will emit
   always_comb begin
      logic [jdf_pkg::WK_W:0]  n_busy;
      logic [jdf_pkg::WK_W:0]  n_fin;
      logic [jdf_pkg::WK_W:0]  n_idle;
      logic [jdf_pkg::WK_W:0]  n_start;
      n_busy = '0;
      n_fin  = '0;
      for (int i = 0; i < jdf_pkg::WORKERS; i++) begin
         n_busy = n_busy + (jdf_pkg::WK_W + 1)'(busy_ff[i]);
         n_fin  = n_fin + (jdf_pkg::WK_W + 1)'(busy_ff[i] &&
                  (rem_ff[i] <= jdf_pkg::JOB_W'(1)));
      end
      n_idle = (jdf_pkg::WK_W + 1)'(jdf_pkg::WORKERS) - n_busy + n_fin;
      if ((jdf_pkg::CNT_W + jdf_pkg::WK_W)'(q_stat.count) <
          (jdf_pkg::CNT_W + jdf_pkg::WK_W)'(n_idle)) begin
         n_start = (jdf_pkg::WK_W + 1)'(q_stat.count);
      end else begin
         n_start = n_idle;
      end
      tick_total = jdf_pkg::EV_W'(n_fin) + jdf_pkg::EV_W'(n_start);
   end

   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      busy_in      = busy_ff;
      job_in       = job_ff;
      rem_in       = rem_ff;
      time_in      = time_ff;
      ev_cnt_in    = ev_cnt_ff;
      ev_total_in  = ev_total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_ctrl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.mode == jdf_pkg::MODE_ADD) begin
                  q_ctrl.push = 1'b1;
               end else begin
                  time_in     = time_ff + 1'b1;
                  ev_total_in = tick_total;
                  ev_cnt_in   = '0;
                  w_in        = '0;
                  state_in    = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (busy_ff[widx] && (rem_ff[widx] <= jdf_pkg::JOB_W'(1))) begin
               if (emit_ok) begin
                  busy_in[widx]       = 1'b0;
                  rem_in[widx]        = '0;
                  rsp_valid_in        = 1'b1;
                  rsp_in.event_kind   = jdf_pkg::EV_FINISHED;
                  rsp_in.worker_index = jdf_pkg::WIDX_W'(w_ff);
                  rsp_in.event_job_id = job_ff[widx];
                  rsp_in.event_length = '0;
                  rsp_in.tick_count   = time_ff;
                  rsp_in.last_event   = is_last;
                  ev_cnt_in           = ev_cnt_ff + 1'b1;
                  if (w_ff == jdf_pkg::WK_W'(jdf_pkg::WORKERS - 1)) begin
                     w_in     = '0;
                     state_in = ST_STR;
                  end else begin
                     w_in = w_ff + 1'b1;
                  end
               end
            end else begin
               if (busy_ff[widx]) begin
                  rem_in[widx] = rem_ff[widx] - 1'b1;
               end
               if (w_ff == jdf_pkg::WK_W'(jdf_pkg::WORKERS - 1)) begin
                  w_in     = '0;
                  state_in = ST_STR;
               end else begin
                  w_in = w_ff + 1'b1;
               end
            end
         end
         ST_STR: begin
            priority if (w_ff == jdf_pkg::WK_W'(jdf_pkg::WORKERS) || q_stat.count == '0) begin
               state_in = ST_IDLE;
            end else if (!busy_ff[widx]) begin
               q_ctrl.rd = 1'b1;
               state_in  = ST_STW;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         ST_STW: begin
            if (emit_ok) begin
               q_ctrl.pop          = 1'b1;
               busy_in[widx]       = 1'b1;
               job_in[widx]        = q_rdata.id;
               rem_in[widx]        = (q_rdata.len == '0) ? jdf_pkg::JOB_W'(1) : q_rdata.len;
               rsp_valid_in        = 1'b1;
               rsp_in.event_kind   = jdf_pkg::EV_STARTED;
               rsp_in.worker_index = jdf_pkg::WIDX_W'(w_ff);
               rsp_in.event_job_id = q_rdata.id;
               rsp_in.event_length = q_rdata.len;
               rsp_in.tick_count   = time_ff;
               rsp_in.last_event   = is_last;
               ev_cnt_in           = ev_cnt_ff + 1'b1;
               w_in                = w_ff + 1'b1;
               state_in            = ST_STR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         w_ff         <= '0;
         busy_ff      <= '0;
         time_ff      <= '0;
         ev_cnt_ff    <= '0;
         ev_total_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < jdf_pkg::WORKERS; i++) begin
            job_ff[i] <= '0;
            rem_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         busy_ff      <= busy_in;
         time_ff      <= time_in;
         ev_cnt_ff    <= ev_cnt_in;
         ev_total_ff  <= ev_total_in;
         rsp_valid_ff <= rsp_valid_in;
         job_ff       <= job_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   jdf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (q_ctrl),
      .wdata (q_wdata),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   a_tick_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_in == ST_IDLE) |=> (ev_cnt_ff == ev_total_ff))
      else $error("tick emitted a different number of events than predicted");

   a_start_has_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STW) |-> (q_stat.count != '0))
      else $error("start read with empty queue");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("result beat overwritten while stalled");

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for job_dispatcher_fifo_agents, job adds and ticks in, events out
// depends on jdf_pkg and the job_dispatcher_fifo_agents rtl; an in-bench dispatch model predicts
// every event, bursty sender and patterned receiver stalls exercise both handshakes

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE_CYCS = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   jdf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   jdf_pkg::rsp_type rsp_data;

   job_dispatcher_fifo_agents u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // dispatch model state
   logic [jdf_pkg::JOB_W-1:0]   pend_id [jdf_pkg::QUEUE_DEPTH];
   logic [jdf_pkg::JOB_W-1:0]   pend_len [jdf_pkg::QUEUE_DEPTH];
   logic [jdf_pkg::QA_W-1:0]    pend_head = '0;
   logic [jdf_pkg::QA_W-1:0]    pend_tail = '0;
   int                          pend_count = 0;
   logic [jdf_pkg::WORKERS-1:0] wk_busy = '0;
   logic [jdf_pkg::JOB_W-1:0]   wk_job [jdf_pkg::WORKERS];
   logic [jdf_pkg::JOB_W-1:0]   wk_left [jdf_pkg::WORKERS];
   logic [jdf_pkg::TIME_W-1:0]  now_ticks = '0;

   jdf_pkg::rsp_type events_due[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   int      burst_left = 0;
   bit      gaps_on = 1'b1;

   function automatic logic [jdf_pkg::QA_W-1:0] ring_step(logic [jdf_pkg::QA_W-1:0] p);
      return (p == jdf_pkg::QA_W'(jdf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic void dispatch_model(jdf_pkg::req_type beat);
      jdf_pkg::rsp_type ev;
      jdf_pkg::rsp_type batch[$];
      if (beat.mode == jdf_pkg::MODE_ADD) begin
         if (pend_count < jdf_pkg::QUEUE_DEPTH) begin
            pend_id[pend_tail]  = beat.job_id;
            pend_len[pend_tail] = beat.job_length;
            pend_tail = ring_step(pend_tail);
            pend_count++;
         end
         return;
      end
      now_ticks = now_ticks + 1'b1;
      for (int w = 0; w < jdf_pkg::WORKERS; w++) begin
         if (wk_busy[w]) begin
            if (wk_left[w] != '0) wk_left[w] = wk_left[w] - 1'b1;
            if (wk_left[w] == '0) begin
               wk_busy[w]      = 1'b0;
               ev.event_kind   = jdf_pkg::EV_FINISHED;
               ev.worker_index = jdf_pkg::WIDX_W'(w);
               ev.event_job_id = wk_job[w];
               ev.event_length = '0;
               ev.tick_count   = now_ticks;
               ev.last_event   = 1'b0;
               batch.push_back(ev);
            end
         end
      end
      for (int w = 0; w < jdf_pkg::WORKERS; w++) begin
         if (!wk_busy[w] && pend_count > 0) begin
            ev.event_kind   = jdf_pkg::EV_STARTED;
            ev.worker_index = jdf_pkg::WIDX_W'(w);
            ev.event_job_id = pend_id[pend_head];
            ev.event_length = pend_len[pend_head];
            ev.tick_count   = now_ticks;
            ev.last_event   = 1'b0;
            pend_head  = ring_step(pend_head);
            pend_count--;
            wk_busy[w] = 1'b1;
            wk_job[w]  = ev.event_job_id;
            wk_left[w] = (ev.event_length == '0) ? jdf_pkg::JOB_W'(1) : ev.event_length;
            batch.push_back(ev);
         end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last_event = 1'b1;
      foreach (batch[i]) events_due.push_back(batch[i]);
   endfunction

   // sender: bursts of beats with random gaps in between
   task automatic send_req(logic mode, logic [jdf_pkg::JOB_W-1:0] id,
                           logic [jdf_pkg::JOB_W-1:0] len);
      int gap;
      jdf_pkg::req_type beat;
      beat.mode       = mode;
      beat.job_id     = id;
      beat.job_length = len;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 5) : 0;
         burst_left = $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      burst_left--;
      do @(posedge clock); while (!req_ready);
      dispatch_model(beat);
   endtask

   task automatic send_tick();
      send_req(jdf_pkg::MODE_TICK, jdf_pkg::JOB_W'($urandom), jdf_pkg::JOB_W'($urandom));
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
   endtask

   // receiver stall pattern
   logic [7:0] stall_mask = 8'hFF;
   int         stall_phase = 0;

   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_phase = 48;
         stall_mask  = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      stall_phase--;
      stall_mask = {stall_mask[0], stall_mask[7:1]};
      rsp_ready <= stall_mask[0];
   end

   function automatic void check_field(string name, logic [jdf_pkg::TIME_W-1:0] exp_v,
                                       logic [jdf_pkg::TIME_W-1:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s expected %0d got %0d", name, exp_v, got_v);
         error_count++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      jdf_pkg::rsp_type exp_ev;
      if (!reset && rsp_valid && rsp_ready) begin
         if (events_due.size() == 0) begin
            $error("event beat with nothing expected");
            error_count++;
         end else begin
            exp_ev = events_due.pop_front();
            check_field("event_kind", jdf_pkg::TIME_W'(exp_ev.event_kind),
                        jdf_pkg::TIME_W'(rsp_data.event_kind));
            check_field("worker_index", jdf_pkg::TIME_W'(exp_ev.worker_index),
                        jdf_pkg::TIME_W'(rsp_data.worker_index));
            check_field("event_job_id", jdf_pkg::TIME_W'(exp_ev.event_job_id),
                        jdf_pkg::TIME_W'(rsp_data.event_job_id));
            check_field("event_length", jdf_pkg::TIME_W'(exp_ev.event_length),
                        jdf_pkg::TIME_W'(rsp_data.event_length));
            check_field("tick_count", exp_ev.tick_count, rsp_data.tick_count);
            check_field("last_event", jdf_pkg::TIME_W'(exp_ev.last_event),
                        jdf_pkg::TIME_W'(rsp_data.last_event));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL job_dispatcher_fifo_agents");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_quiet_ticks();
      send_req(jdf_pkg::MODE_TICK, 16'hFFFF, 16'hFFFF);
      send_req(jdf_pkg::MODE_TICK, 16'h0000, 16'h0000);
   endtask

   task automatic test_field_extremes();
      send_req(jdf_pkg::MODE_ADD, 16'h0000, 16'h0000);
      send_req(jdf_pkg::MODE_ADD, 16'hFFFF, 16'h0001);
      send_req(jdf_pkg::MODE_ADD, 16'h5A5A, 16'h0002);
      send_req(jdf_pkg::MODE_ADD, 16'hA5A5, 16'h0000);
      send_req(jdf_pkg::MODE_ADD, 16'h8001, 16'h0003);
      repeat (6) send_tick();
      hold_until_drained();
   endtask

   task automatic test_queue_full();
      repeat (jdf_pkg::QUEUE_DEPTH + 2)
         send_req(jdf_pkg::MODE_ADD, jdf_pkg::JOB_W'($urandom),
                  jdf_pkg::JOB_W'($urandom_range(0, 2)));
      while (pend_count > 0 || wk_busy != '0) send_tick();
   endtask

   task automatic test_random_traffic();
      int sent;
      int adds;
      int ticks;
      logic [jdf_pkg::JOB_W-1:0] len;
      sent = 0;
      while (sent < 40) begin
         gaps_on = !(sent >= 12 && sent < 26);
         adds  = $urandom_range(0, 5);
         ticks = $urandom_range(1, 6);
         repeat (adds) begin
            len = ($urandom_range(0, 9) == 0) ? jdf_pkg::JOB_W'($urandom_range(6, 40))
                                               : jdf_pkg::JOB_W'($urandom_range(0, 5));
            send_req(jdf_pkg::MODE_ADD, jdf_pkg::JOB_W'($urandom), len);
         end
         repeat (ticks) send_tick();
         sent += adds + ticks;
         if (sent >= 20 && sent < 20 + adds + ticks) hold_until_drained();
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_long_job();
      send_req(jdf_pkg::MODE_ADD, jdf_pkg::JOB_W'($urandom), 16'hFFFF);
      send_req(jdf_pkg::MODE_ADD, 16'hFFFF, 16'h0001);
      while (pend_count > 0) send_tick();
      repeat (3) send_tick();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_quiet_ticks();
      test_field_extremes();
      test_queue_full();
      test_random_traffic();
      test_long_job();
      hold_until_drained();
      repeat (SETTLE_CYCS) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS job_dispatcher_fifo_agents");
      end else begin
         $display("FAIL job_dispatcher_fifo_agents");
      end
      $finish;
   end

endmodule
